// ----- rtl/cbm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_pkg - shared types and constants of the cartridge bank mapper
// Item structs for both channels, write strobe bundle, decode codes.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Control decoder: address bits 15:14
  localparam logic [1:0] CTL_BLK_8000 = 2'b10;

  // Control decoder: address bits 3:2
  localparam logic [1:0] CTL_MIRROR  = 2'b01;
  localparam logic [1:0] CTL_IRQ_ACK = 2'b01;
  localparam logic [1:0] CTL_IRQ_EN  = 2'b10;
  localparam logic [1:0] CTL_IRQ_TOP = 2'b11;

  // Bank decoder: address bits 15:12
  localparam logic [3:0] BNK_PRG0  = 4'h8;
  localparam logic [3:0] BNK_HBIT  = 4'h9;
  localparam logic [3:0] BNK_PRG1  = 4'hA;
  localparam logic [3:0] BNK_NONE  = 4'hF;

  localparam logic [15:0] CHR_BASE = 16'hB000;

  // Dot prescaler and IRQ counter
  localparam logic [3:0] PHASE_STEP = 4'd6;
  localparam logic [3:0] PHASE_WRAP = 4'd8;
  localparam logic [6:0] IRQ_FIRE   = 7'd84;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  wdata;
    logic        counting;
    logic        line_end;
  } cbm_in_t;

  typedef struct packed {
    logic        irq_line;
    logic [1:0]  mirror_mode;
    logic [7:0]  prg_bank_low;
    logic [7:0]  prg_bank_high;
    logic [63:0] chr_banks;
  } cbm_out_t;

  typedef struct packed {
    logic       mirror_we;
    logic       irq_set;
    logic       irq_ack;
    logic       irq_en_set;
    logic       irq_clear;
    logic       prg0_we;
    logic       prg1_we;
    logic       hbit_we;
    logic       chr_we;
    logic [2:0] chr_idx;
    logic       chr_hi;
  } cbm_wr_t;

endpackage

// ----- rtl/cartridge_bank_mapper_with_dot_irq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_dot_irq - banking chip with dot-driven IRQ
// One input register, one result register: 1 item per cycle unless stalled.
// An accepted item waits in the input register until the result one is free.
// Reset: synchronous active-low; clears all mapper state and both valid flags.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_dot_irq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cbm_pkg::cbm_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output cbm_pkg::cbm_out_t out_item
);
  import cbm_pkg::*;

  // Input register: hold the accepted item for decode
  logic     s1_valid_r, s1_valid_nxt;
  cbm_in_t  s1_item_r;
  // Result register
  logic     out_valid_r, out_valid_nxt;
  cbm_out_t out_item_r;

  cbm_wr_t  wr;
  cbm_out_t result_nxt;
  logic     advance;   // result register free or being emptied
  logic     apply;     // commit the held item to state this cycle

  assign advance  = !out_valid_r || !out_stall;
  assign apply    = s1_valid_r && advance;
  // Take a new item whenever the input register is empty or empties this cycle
  assign in_stall = s1_valid_r && !advance;

  assign s1_valid_nxt  = in_valid || (s1_valid_r && !advance);
  assign out_valid_nxt = apply || (out_valid_r && out_stall);

  cbm_decode u_decode (
    .item (s1_item_r),
    .wr   (wr)
  );

  cbm_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .apply      (apply),
    .item       (s1_item_r),
    .wr         (wr),
    .result_nxt (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on acceptance, hold otherwise
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item_r <= in_item;
    end
    if (apply) begin
      out_item_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("valid flags not cleared by reset");

  a_apply_shows : assert property (@(posedge clk) disable iff (!rst_n)
    apply |=> out_valid_r)
    else $error("committed item produced no result");

  a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("held item dropped while result stalled");

endmodule

// ----- rtl/cbm_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_decode - CPU write address decoders
// Control decoder on bits 15:14 and 3:2, bank decoder on bits 15:12.
// ----------------------------------------------------------------------------
module cbm_decode (
  input  cbm_pkg::cbm_in_t item,
  output cbm_pkg::cbm_wr_t wr
);
  import cbm_pkg::*;

  logic        wr_hit;
  logic        blk_8000;
  logic [1:0]  low2;
  logic [3:0]  hi4;
  logic [15:0] chr_off;

  assign wr_hit   = (item.kind == KIND_WRITE) && item.address[15];
  assign blk_8000 = (item.address[15:14] == CTL_BLK_8000);
  assign low2     = item.address[3:2];
  assign hi4      = item.address[15:12];
  assign chr_off  = item.address - CHR_BASE;

  always_comb begin
    wr            = '0;
    wr.chr_idx    = chr_off[13:11] | {2'b00, item.address[1]};
    wr.chr_hi     = item.address[0];
    if (wr_hit) begin
      if (blk_8000) begin
        wr.mirror_we  = (low2 == CTL_MIRROR);
        wr.irq_set    = (low2 == CTL_IRQ_TOP);
      end else begin
        wr.irq_ack    = (low2 == CTL_IRQ_ACK);
        wr.irq_en_set = (low2 == CTL_IRQ_EN);
        wr.irq_clear  = (low2 == CTL_IRQ_TOP);
      end
      wr.prg0_we = (hi4 == BNK_PRG0);
      wr.hbit_we = (hi4 == BNK_HBIT);
      wr.prg1_we = (hi4 == BNK_PRG1);
      wr.chr_we  = (hi4 != BNK_PRG0) && (hi4 != BNK_HBIT) &&
                   (hi4 != BNK_PRG1) && (hi4 != BNK_NONE);
    end
  end

endmodule

// ----- rtl/cbm_state.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_state - mapper registers, dot prescaler and IRQ counter
// Apply one item when enabled and present the resulting mapper state.
// ----------------------------------------------------------------------------
module cbm_state (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              apply,
  input  cbm_pkg::cbm_in_t  item,
  input  cbm_pkg::cbm_wr_t  wr,
  output cbm_pkg::cbm_out_t result_nxt
);
  import cbm_pkg::*;

  logic [7:0] prg_r   [2];
  logic [7:0] prg_nxt [2];
  logic [7:0] chr_r   [8];
  logic [7:0] chr_nxt [8];
  logic [1:0] mirror_sel_r, mirror_sel_nxt;
  logic       mirror_hbit_r, mirror_hbit_nxt;
  logic       irq_enable_r, irq_enable_nxt;
  logic [6:0] irq_count_r, irq_count_nxt;
  logic [3:0] dot_phase_r, dot_phase_nxt;
  logic       irq_pending_r, irq_pending_nxt;

  logic [3:0] phase_inc;
  logic [6:0] count_inc;
  logic       is_tick;

  assign is_tick   = (item.kind == KIND_TICK);
  assign phase_inc = dot_phase_r + 4'd1;
  assign count_inc = irq_count_r + 7'd1;

  always_comb begin
    prg_nxt         = prg_r;
    chr_nxt         = chr_r;
    mirror_sel_nxt  = mirror_sel_r;
    mirror_hbit_nxt = mirror_hbit_r;
    irq_enable_nxt  = irq_enable_r;
    irq_count_nxt   = irq_count_r;
    dot_phase_nxt   = dot_phase_r;
    irq_pending_nxt = irq_pending_r;
    if (is_tick) begin
      if (item.counting) begin
        dot_phase_nxt = phase_inc;
        if (phase_inc == PHASE_STEP) begin
          if (irq_enable_r) begin
            if (count_inc == IRQ_FIRE) begin
              irq_pending_nxt = 1'b1;
              irq_count_nxt   = '0;
            end else begin
              irq_count_nxt = count_inc;
            end
          end
        end else if (phase_inc == PHASE_WRAP) begin
          dot_phase_nxt = '0;
        end
      end
      if (item.line_end) begin
        dot_phase_nxt = '0;
      end
    end else begin
      if (wr.mirror_we)  mirror_sel_nxt  = item.wdata[1:0];
      if (wr.irq_set)    irq_pending_nxt = 1'b1;
      if (wr.irq_ack)    irq_pending_nxt = 1'b0;
      if (wr.irq_en_set) irq_enable_nxt  = 1'b1;
      if (wr.irq_clear) begin
        irq_pending_nxt = 1'b0;
        irq_enable_nxt  = 1'b0;
        irq_count_nxt   = '0;
      end
      if (wr.prg0_we) prg_nxt[0]      = item.wdata;
      if (wr.prg1_we) prg_nxt[1]      = item.wdata;
      if (wr.hbit_we) mirror_hbit_nxt = item.wdata[0];
      if (wr.chr_we) begin
        if (wr.chr_hi) chr_nxt[wr.chr_idx][7:4] = item.wdata[3:0];
        else           chr_nxt[wr.chr_idx][3:0] = item.wdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_r         <= '{default: '0};
      chr_r         <= '{default: '0};
      mirror_sel_r  <= '0;
      mirror_hbit_r <= 1'b0;
      irq_enable_r  <= 1'b0;
      irq_count_r   <= '0;
      dot_phase_r   <= '0;
      irq_pending_r <= 1'b0;
    end else if (apply) begin
      prg_r         <= prg_nxt;
      chr_r         <= chr_nxt;
      mirror_sel_r  <= mirror_sel_nxt;
      mirror_hbit_r <= mirror_hbit_nxt;
      irq_enable_r  <= irq_enable_nxt;
      irq_count_r   <= irq_count_nxt;
      dot_phase_r   <= dot_phase_nxt;
      irq_pending_r <= irq_pending_nxt;
    end
  end

  // Result reflects the state after this item
  always_comb begin
    result_nxt.irq_line      = irq_pending_nxt;
    result_nxt.mirror_mode   = mirror_sel_nxt[1] ? mirror_sel_nxt
                                                 : {1'b0, mirror_hbit_nxt};
    result_nxt.prg_bank_low  = prg_nxt[0];
    result_nxt.prg_bank_high = prg_nxt[1];
    for (int i = 0; i < 8; i++) begin
      result_nxt.chr_banks[8*i +: 8] = chr_nxt[i];
    end
  end

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    irq_count_r < IRQ_FIRE)
    else $error("irq counter reached fire value without wrapping");

  a_phase_range : assert property (@(posedge clk) disable iff (!rst_n)
    dot_phase_r <= PHASE_WRAP)
    else $error("dot prescaler left its range");

  a_irq_clear : assert property (@(posedge clk) disable iff (!rst_n)
    apply && !is_tick && wr.irq_clear |=>
      !irq_pending_r && !irq_enable_r && (irq_count_r == '0))
    else $error("IRQ disable-and-clear write did not clear IRQ state");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the cartridge bank mapper with dot IRQ
// Streams CPU writes and video dot ticks through the mapper, with random
// idling on both channels, and checks every result item against a local
// model of the banking registers, the mirroring select and the IRQ counter.
// ----------------------------------------------------------------------------
module tb;
  import cbm_pkg::*;

  // Upper two address bits of the IRQ control block at 0xC000
  localparam logic [1:0] CTL_BLK_C000 = 2'b11;
  // Items left in the queue when the quiet tail starts (no idling)
  localparam int TAIL_QUIET = 150;
  // Dots per scanline; the last one carries line_end
  localparam int LINE_DOTS = 341;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cbm_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cbm_out_t out_item;

  cartridge_bank_mapper_with_dot_irq uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Stimulus waiting to be sent, and the views of the mapper still owed
  cbm_in_t  pending_items[$];
  cbm_out_t expected_views[$];
  cbm_out_t oldest_view;
  int       stim_total = 0;
  int       items_taken = 0;
  int       fail_count = 0;
  int       send_gap = 0;
  int       hold_left = 0;

  // Local copy of the mapper's state
  logic [7:0] bank_prg[2];
  logic [7:0] bank_chr[8];
  logic [1:0] mir_sel;
  logic       mir_hbit;
  logic       irq_en;
  logic [6:0] irq_cnt;
  logic [3:0] phase;
  logic       irq_flag;

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one item to the local state and return the outputs it leaves behind
  function automatic cbm_out_t next_mapper_view(input cbm_in_t it);
    logic [15:0] chr_off;
    logic [2:0]  slot;
    cbm_out_t    view;
    if (it.kind == KIND_TICK) begin
      // Prescaler only moves while rendering is counted; line end always
      // pulls it back to zero
      if (it.counting) begin
        phase = phase + 4'd1;
        if (phase == PHASE_STEP) begin
          if (irq_en) begin
            irq_cnt = irq_cnt + 7'd1;
            if (irq_cnt == IRQ_FIRE) begin
              irq_flag = 1'b1;
              irq_cnt = '0;
            end
          end
        end else if (phase == PHASE_WRAP) begin
          phase = '0;
        end
      end
      if (it.line_end) begin
        phase = '0;
      end
    end else if (it.address[15]) begin
      // Control decoder: bits 15:14 pick the block, bits 3:2 the action
      if (it.address[15:14] == CTL_BLK_8000) begin
        if (it.address[3:2] == CTL_MIRROR) begin
          mir_sel = it.wdata[1:0];
        end else if (it.address[3:2] == CTL_IRQ_TOP) begin
          irq_flag = 1'b1;
        end
      end else begin
        if (it.address[3:2] == CTL_IRQ_ACK) begin
          irq_flag = 1'b0;
        end else if (it.address[3:2] == CTL_IRQ_EN) begin
          irq_en = 1'b1;
        end else if (it.address[3:2] == CTL_IRQ_TOP) begin
          irq_flag = 1'b0;
          irq_en = 1'b0;
          irq_cnt = '0;
        end
      end
      // Bank decoder works on the same write, independently
      unique case (it.address[15:12])
        BNK_PRG0: bank_prg[0] = it.wdata;
        BNK_HBIT: mir_hbit = it.wdata[0];
        BNK_PRG1: bank_prg[1] = it.wdata;
        BNK_NONE: ;
        default: begin
          // Two addresses may land on the same entry through bit 1, ORed onto bit 11
          chr_off = it.address - CHR_BASE;
          slot = chr_off[13:11] | {2'b00, it.address[1]};
          if (it.address[0]) begin
            bank_chr[slot][7:4] = it.wdata[3:0];
          end else begin
            bank_chr[slot][3:0] = it.wdata[3:0];
          end
        end
      endcase
    end
    view.irq_line      = irq_flag;
    view.mirror_mode   = mir_sel[1] ? mir_sel : {1'b0, mir_hbit};
    view.prg_bank_low  = bank_prg[0];
    view.prg_bank_high = bank_prg[1];
    for (int i = 0; i < 8; i++) begin
      view.chr_banks[8*i +: 8] = bank_chr[i];
    end
    return view;
  endfunction

  // Idling runs in stretches, with every third stretch calm, and stops
  // altogether in the tail of the run
  function automatic bit idle_allowed();
    return pending_items.size() > TAIL_QUIET && ((items_taken / 128) % 3) != 2;
  endfunction

  // Queue a CPU write; the tick-only fields carry junk
  task automatic queue_write(input logic [15:0] addr, input logic [7:0] data);
    cbm_in_t it;
    it.kind     = KIND_WRITE;
    it.address  = addr;
    it.wdata    = data;
    it.counting = 1'($urandom);
    it.line_end = 1'($urandom);
    pending_items.push_back(it);
    stim_total++;
  endtask

  // Queue a dot tick; address and data carry junk
  task automatic queue_tick(input logic cnt, input logic le);
    cbm_in_t it;
    it.kind     = KIND_TICK;
    it.address  = 16'($urandom);
    it.wdata    = 8'($urandom);
    it.counting = cnt;
    it.line_end = le;
    pending_items.push_back(it);
    stim_total++;
  endtask

  // Driver: hold the item while stalled, advance once it is taken, and
  // insert idle bursts between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_views.push_back(next_mapper_view(in_item));
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (idle_allowed() && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 11);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest expected view, and
  // throttle the result channel with stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          $error("result item with no expected view waiting");
          fail_count++;
        end else begin
          oldest_view = expected_views.pop_front();
          if (out_item.irq_line !== oldest_view.irq_line) begin
            $error("irq_line: expected %0h, got %0h",
                   oldest_view.irq_line, out_item.irq_line);
            fail_count++;
          end
          if (out_item.mirror_mode !== oldest_view.mirror_mode) begin
            $error("mirror_mode: expected %0h, got %0h",
                   oldest_view.mirror_mode, out_item.mirror_mode);
            fail_count++;
          end
          if (out_item.prg_bank_low !== oldest_view.prg_bank_low) begin
            $error("prg_bank_low: expected %0h, got %0h",
                   oldest_view.prg_bank_low, out_item.prg_bank_low);
            fail_count++;
          end
          if (out_item.prg_bank_high !== oldest_view.prg_bank_high) begin
            $error("prg_bank_high: expected %0h, got %0h",
                   oldest_view.prg_bank_high, out_item.prg_bank_high);
            fail_count++;
          end
          if (out_item.chr_banks !== oldest_view.chr_banks) begin
            $error("chr_banks: expected %0h, got %0h",
                   oldest_view.chr_banks, out_item.chr_banks);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (idle_allowed() && $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [15:0] addr;
    int          seg_len;
    int          pick;

    bank_prg = '{default: '0};
    bank_chr = '{default: '0};
    mir_sel  = '0;
    mir_hbit = 1'b0;
    irq_en   = 1'b0;
    irq_cnt  = '0;
    phase    = '0;
    irq_flag = 1'b0;

    // Directed: writes below the mapper window are dropped
    queue_write(16'h0000, 8'hFF);
    // Program banks, at both data extremes; 0x8004 also hits the mirror select
    queue_write(16'h8000, 8'hFF);
    queue_write(16'h8004, 8'h02);
    queue_write(16'h8004, 8'h03);
    queue_write(16'h9000, 8'h01);
    queue_write(16'h8004, 8'h00);
    queue_write(16'hA000, 8'hFF);
    queue_write(16'hA000, 8'h00);
    // Pattern bank nibbles at both ends of the window and an aliased entry
    queue_write(16'hB000, 8'h0F);
    queue_write(16'hB003, 8'hFA);
    queue_write(16'hBFFF, 8'hF7);
    queue_write(16'hE802, 8'h5C);
    queue_write(16'hEFFF, 8'h9E);
    queue_write(16'hFFFF, 8'hFF);
    // IRQ raise, acknowledge, raise again, clear all, enable
    queue_write({CTL_BLK_8000, 10'h000, CTL_IRQ_TOP, 2'b00}, 8'h00);
    queue_write({CTL_BLK_C000, 10'h000, CTL_IRQ_ACK, 2'b00}, 8'h00);
    queue_write({CTL_BLK_8000, 10'h000, CTL_IRQ_TOP, 2'b00}, 8'h00);
    queue_write({CTL_BLK_C000, 10'h000, CTL_IRQ_TOP, 2'b00}, 8'h00);
    queue_write({CTL_BLK_C000, 10'h000, CTL_IRQ_EN, 2'b00}, 8'h00);
    // Ticks: idle dot, line end while counting, then up to the step phase
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b1, 1'b1);
    for (int k = 0; k < 6; k++) begin
      queue_tick(1'b1, 1'b0);
    end

    // One long counted stretch from a cleared counter, so the IRQ fires
    addr = 16'($urandom);
    addr[15:14] = CTL_BLK_C000;
    addr[3:2] = CTL_IRQ_TOP;
    queue_write(addr, 8'($urandom));
    addr[3:2] = CTL_IRQ_EN;
    queue_write(addr, 8'($urandom));
    for (int k = 0; k < 720; k++) begin
      queue_tick(1'b1, (k % LINE_DOTS) == LINE_DOTS - 1);
    end

    // Random mix of dot runs, bank writes, IRQ control and raw noise
    while (stim_total < 1275) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        seg_len = $urandom_range(16, 120);
        for (int k = 0; k < seg_len; k++) begin
          queue_tick($urandom_range(0, 7) != 0, $urandom_range(0, 31) == 0);
        end
      end else if (pick < 15) begin
        // Bank writes; keep the 0xC000 block off the clearing actions
        seg_len = $urandom_range(1, 4);
        for (int k = 0; k < seg_len; k++) begin
          addr = 16'($urandom);
          addr[15] = 1'b1;
          if (addr[14]) begin
            addr[2] = 1'b0;
          end
          queue_write(addr, 8'($urandom));
        end
      end else if (pick < 17) begin
        addr = 16'($urandom);
        seg_len = $urandom_range(0, 7);
        if (seg_len < 4) begin
          addr[15:14] = CTL_BLK_C000;
          addr[3:2] = CTL_IRQ_EN;
        end else if (seg_len < 6) begin
          addr[15:14] = CTL_BLK_C000;
          addr[3:2] = CTL_IRQ_ACK;
        end else if (seg_len == 6) begin
          addr[15:14] = CTL_BLK_8000;
          addr[3:2] = CTL_IRQ_TOP;
        end else begin
          addr[15:14] = CTL_BLK_C000;
          addr[3:2] = CTL_IRQ_TOP;
        end
        queue_write(addr, 8'($urandom));
      end else begin
        // Noise: any kind, any field value
        seg_len = $urandom_range(1, 3);
        for (int k = 0; k < seg_len; k++) begin
          if ($urandom_range(0, 1) == 0) begin
            queue_write(16'($urandom), 8'($urandom));
          end else begin
            queue_tick(1'($urandom), 1'($urandom));
          end
        end
      end
    end

    // Hold reset, then release it for good
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every view to be checked
    while (items_taken != stim_total) @(negedge clk);
    while (expected_views.size() != 0) @(negedge clk);
    // Run on past the input and result registers, so stray results are caught
    repeat (8) @(negedge clk);

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: about 1300 items, each delayed at worst by an idle gap, a stall
  // burst and the pipe, end well before the limit; allow 5 ms
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
